// File: src/md5_stream_hasher_macros.svh
// Assertion macros used by the hasher core.
`ifndef MD5_STREAM_HASHER_MACROS_SVH
`define MD5_STREAM_HASHER_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define MD5_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("md5 assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define MD5_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("md5 assertion failed");

`endif

// File: src/md5sh_pkg.sv
`timescale 1ns / 1ps
package md5sh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5sh_req_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    begin
      case ({i[5:4], i[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] g;
    begin
      case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: g = 4'(5 * i[3:0] + 1);
        2'd2: g = 4'(3 * i[3:0] + 5);
        default: g = 4'(7 * i[3:0]);
      endcase
      return g;
    end
  endfunction

endpackage

// File: src/md5_stream_hasher.sv
`timescale 1ns / 1ps
// Channel   | Ports                                         | Handshake
// input     | in_data_byte, in_has_byte, in_end_of_message  | in_push / in_full
// result    | out_digest_word, out_word_index, out_last_word| out_pop / out_empty
// A request without a block boundary or end is absorbed by the back end in S_IDLE.
// A completed block: setup, 64 rounds in the single round unit, then the chaining add.
// A message end adds one or two padding blocks of hashing,
// then four digest words are offered.
// A two-entry request queue lets pushes continue while the round unit is busy.
// Reset (rst_n low, synchronous) restores the initial chaining words and clears counts.
module md5_stream_hasher
  import md5sh_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);
  md5sh_req_t wr_req, rd_req;
  logic       q_empty, take;

  // Idle requests carry no work and are dropped at the front.
  assign wr_req = '{data_byte: in_data_byte, has_byte: in_has_byte,
                    end_of_message: in_end_of_message};

  md5sh_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_push && (in_has_byte || in_end_of_message)),
    .wr_data(wr_req), .full(in_full),
    .rd_en(take), .rd_data(rd_req), .empty(q_empty)
  );

  md5sh_core u_core (
    .clk(clk), .rst_n(rst_n),
    .req(rd_req), .req_valid(!q_empty), .req_take(take),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word), .out_empty(out_empty), .pop(out_pop)
  );
endmodule

// File: src/md5sh_queue.sv
`timescale 1ns / 1ps
module md5sh_queue
  import md5sh_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  md5sh_req_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output md5sh_req_t rd_data,
  output logic       empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  md5sh_req_t          mem_r [DEPTH];
  logic [AW-1:0]       wp_r, rp_r;
  logic [AW:0]         cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule

// File: src/md5sh_core.sv
`timescale 1ns / 1ps
`include "md5_stream_hasher_macros.svh"
module md5sh_core
  import md5sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  md5sh_req_t  req,
  input  logic        req_valid,
  output logic        req_take,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_empty,
  input  logic        pop
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_ADD   = 6'b000100,
    S_PAD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t        st_r, st_nxt;
  logic [31:0]   chain_r [4];
  logic [31:0]   blk_r [16];
  logic [31:0]   a_r, b_r, c_r, d_r;
  logic [63:0]   bits_r;
  logic [5:0]    pos_r;
  logic [5:0]    rnd_r;
  logic          fin_r;
  logic          tail_r;
  logic [1:0]    oidx_r;

  logic [31:0]   f, sum, rot;
  logic [4:0]    s;
  logic [5:0]    pos_inc;
  logic          pad_len;

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = d_r ^ (b_r & (c_r ^ d_r));
      2'd1: f = c_r ^ (d_r & (b_r ^ c_r));
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s   = rot_amount(rnd_r);
    sum = a_r + f + round_const(rnd_r) + blk_r[msg_index(rnd_r)];
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  assign pos_inc         = pos_r + 6'd1;
  assign pad_len         = !fin_r || (pos_r < 6'd56);
  assign req_take        = (st_r == S_IDLE) && req_valid;
  assign out_empty       = (st_r != S_OUT);
  assign out_digest_word = chain_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 2'd3);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (req_valid) begin
        if (req.has_byte && pos_inc == '0) st_nxt = S_RUN;
        else if (req.end_of_message) st_nxt = S_PAD;
      end
      S_RUN: if (rnd_r == 6'd63) st_nxt = S_ADD;
      S_ADD: st_nxt = fin_r ? (tail_r ? S_PAD : S_OUT) : (tail_r ? S_PAD : S_IDLE);
      S_PAD: st_nxt = S_RUN;
      S_LEN: st_nxt = S_RUN;
      S_OUT: if (pop && oidx_r == 2'd3) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
      bits_r     <= '0;
      pos_r      <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      tail_r     <= 1'b0;
      oidx_r     <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (req_valid) begin
          if (req.has_byte) begin
            blk_r[pos_r[5:2]][8*pos_r[1:0] +: 8] <= req.data_byte;
            bits_r <= bits_r + 64'd8;
            pos_r  <= pos_inc;
          end
          fin_r  <= req.end_of_message;
          tail_r <= req.end_of_message;
          a_r <= chain_r[0]; b_r <= chain_r[1]; c_r <= chain_r[2]; d_r <= chain_r[3];
          rnd_r <= '0;
        end
        S_RUN: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          rnd_r <= rnd_r + 6'd1;
        end
        S_ADD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          a_r <= chain_r[0] + a_r; b_r <= chain_r[1] + b_r;
          c_r <= chain_r[2] + c_r; d_r <= chain_r[3] + d_r;
          oidx_r <= '0;
        end
        S_PAD: begin
          // Marker (first pad block), zero fill; length in last two words when it fits.
          for (int w = 0; w < 16; w++) begin
            for (int l = 0; l < 4; l++) begin
              if (pad_len && w == 14) begin
                blk_r[w][8*l +: 8] <= bits_r[8*l +: 8];
              end else if (pad_len && w == 15) begin
                blk_r[w][8*l +: 8] <= bits_r[32 + 8*l +: 8];
              end else if (fin_r) begin
                if (6'(4*w + l) == pos_r) blk_r[w][8*l +: 8] <= PAD_MARK;
                else if (6'(4*w + l) > pos_r) blk_r[w][8*l +: 8] <= 8'h00;
              end else begin
                blk_r[w][8*l +: 8] <= 8'h00;
              end
            end
          end
          fin_r  <= pad_len;
          tail_r <= !pad_len;
          rnd_r  <= '0;
        end
        S_LEN: rnd_r <= '0;
        S_OUT: if (pop) begin
          oidx_r <= oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            chain_r[0] <= IV_A; chain_r[1] <= IV_B;
            chain_r[2] <= IV_C; chain_r[3] <= IV_D;
            bits_r <= '0;
            pos_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `MD5_ASSERT_IMP(a_out_rst, clk, rst_n, !out_empty, st_r == S_OUT)
  `MD5_ASSERT_NEXT(a_run_cnt, clk, rst_n, st_r == S_RUN && rnd_r != 6'd63, st_r == S_RUN)
  `MD5_ASSERT_IMP(a_take_idle, clk, rst_n, req_take, out_empty)
endmodule
